// ----- hdl/dbcs_pkg.sv -----
package dbcs_pkg;

  localparam int DEF_MAX_COLS = 8;
  localparam int DEF_MAX_ROWS = 8;

  localparam int GLYPH_W = 8;
  localparam int POS_W   = 3;
  localparam int REG_W   = 4;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'd32;
  localparam logic [REG_W-1:0]   COLS_RESET  = 4'd8;
  localparam logic [REG_W-1:0]   ROWS_RESET  = 4'd8;

  // Configuration register indexes.
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // Input commands.
  typedef enum logic {
    CMD_DRAW    = 1'b0,
    CMD_PRESENT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_t;

  // Read request from the scan sequencer to both frame stores.
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } scan_req_t;

endpackage

// ----- hdl/dbcs_frame_store.sv -----
module dbcs_frame_store
  import dbcs_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS,
  parameter int ADDR_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [GLYPH_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [GLYPH_W-1:0] rdata
);

  logic [GLYPH_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   written;
  logic [GLYPH_W-1:0] rd_q;
  logic               rv_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // An entry never written since reset reads as a space.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rv_q <= written[raddr];
      end
    end
  end

  assign rdata = rv_q ? rd_q : GLYPH_SPACE;

endmodule

// ----- hdl/dbcs_scan_ctrl.sv -----
module dbcs_scan_ctrl
  import dbcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [REG_W-1:0]   eff_w,
  input  logic [REG_W-1:0]   eff_h,
  output logic               busy,
  output logic               back_sel,
  output scan_req_t          scan_req,
  input  logic [GLYPH_W-1:0] glyph_a,
  input  logic [GLYPH_W-1:0] glyph_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cell_valid,
  output logic [POS_W-1:0]   out_col,
  output logic [POS_W-1:0]   out_row,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic               last
);

  state_t state, state_next;

  logic [POS_W-1:0]   x, y;
  logic               first_pending;
  logic               pend_valid;
  logic [POS_W-1:0]   pend_col, pend_row;
  logic [GLYPH_W-1:0] pend_glyph;

  logic [GLYPH_W-1:0] back_g, front_g;
  logic slot_free, hit, end_x, end_y, last_cell, cmp_go, push, fin, empty_area;

  assign slot_free  = !out_valid || out_ready;
  assign back_g     = back_sel ? glyph_b : glyph_a;
  assign front_g    = back_sel ? glyph_a : glyph_b;
  assign hit        = first_pending || (back_g != front_g);
  assign end_x      = (REG_W'(x) + REG_W'(1)) == eff_w;
  assign end_y      = (REG_W'(y) + REG_W'(1)) == eff_h;
  assign last_cell  = end_x && end_y;
  assign empty_area = (eff_w == '0) || (eff_h == '0);
  // A new hit can only be taken once the held one has gone to the output.
  assign cmp_go     = !(hit && pend_valid) || slot_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = empty_area ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_go) begin
          state_next = last_cell ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    scan_req.en = (state == ST_READ);
    scan_req.x  = x;
    scan_req.y  = y;
    push        = (state == ST_CMP) && cmp_go && hit && pend_valid;
    fin         = (state == ST_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_pending <= 1'b1;
      back_sel      <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        pend_valid <= 1'b0;
      end else if (state == ST_CMP && cmp_go && hit) begin
        pend_valid <= 1'b1;
      end
      if (push || fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fin) begin
        back_sel      <= !back_sel;
        first_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      x <= '0;
      y <= '0;
    end else if (state == ST_CMP && cmp_go) begin
      if (hit) begin
        pend_col   <= x;
        pend_row   <= y;
        pend_glyph <= back_g;
      end
      if (end_x) begin
        x <= '0;
        y <= y + POS_W'(1);
      end else begin
        x <= x + POS_W'(1);
      end
    end
  end

  // The held hit goes out only when the next one shows up or the scan ends,
  // so the final beat of a present can carry last.
  always_ff @(posedge clk) begin
    if (push) begin
      cell_valid <= 1'b1;
      out_col    <= pend_col;
      out_row    <= pend_row;
      out_glyph  <= pend_glyph;
      last       <= 1'b0;
    end else if (fin) begin
      cell_valid <= pend_valid;
      out_col    <= pend_valid ? pend_col : '0;
      out_row    <= pend_valid ? pend_row : '0;
      out_glyph  <= pend_valid ? pend_glyph : '0;
      last       <= 1'b1;
    end
  end

endmodule

// ----- hdl/double_buffered_cell_diff_screen_core.sv -----
// Character-cell screen kept in two ping-pong frame stores.
// Input channel (in_valid/in_ready): cmd 0 draws glyph at (col,row) into the
// back frame; cells outside the active area are dropped. cmd 1 presents: the
// active cells are scanned in row-major order and every cell whose back glyph
// differs from the front glyph leaves as one beat on the output channel
// (out_valid/out_ready), the final beat flagged by last. The first present
// after reset sends every active cell. A present with nothing to send gives a
// single beat with cell_valid 0 and last 1. The frames swap after each present.
// A draw leaves the block ready. During a present each active cell goes
// through the registered frame store read followed by the shared compare
// stage; in_ready is low meanwhile. A held hit is released when the next hit
// is found or the scan ends. When the receiver stalls, the scan waits at the
// next hit; a new item can be accepted while the final beat still waits in
// the output register. Reset clears both frames to spaces, makes store a the
// back frame and sets the active area to 8 by 8. cols_in_use and rows_in_use
// (cfg_index 0 and 1) are written through cfg_we; the user must write them
// only while the block is idle, as the block itself does not enforce it.
module double_buffered_cell_diff_screen_core
  import dbcs_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [REG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic signed [7:0]  col,
  input  logic signed [7:0]  row,
  input  logic [GLYPH_W-1:0] glyph,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cell_valid,
  output logic [POS_W-1:0]   out_col,
  output logic [POS_W-1:0]   out_row,
  output logic [GLYPH_W-1:0] out_glyph,
  output logic               last
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [REG_W-1:0] COLS_MAX4 = REG_W'(MAX_COLS);
  localparam logic [REG_W-1:0] ROWS_MAX4 = REG_W'(MAX_ROWS);
  localparam logic [6:0]       COLS7     = 7'(MAX_COLS);

  logic [REG_W-1:0]   cols_in_use, rows_in_use;
  logic [REG_W-1:0]   eff_w, eff_h;
  logic               busy, back_sel, draw_ok, we_a, we_b;
  logic [6:0]         waddr_full, raddr_full;
  logic [GLYPH_W-1:0] glyph_a, glyph_b;
  scan_req_t          scan_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_RESET;
      rows_in_use <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS: cols_in_use <= cfg_data;
        CFG_ROWS: rows_in_use <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign eff_w = (cols_in_use > COLS_MAX4) ? COLS_MAX4 : cols_in_use;
  assign eff_h = (rows_in_use > ROWS_MAX4) ? ROWS_MAX4 : rows_in_use;

  assign in_ready = !busy;

  // Negative coordinates have bit 7 set and fail the unsigned compare.
  assign draw_ok = in_valid && in_ready && (cmd == CMD_DRAW)
                   && ($unsigned(col) < {4'b0000, eff_w})
                   && ($unsigned(row) < {4'b0000, eff_h});
  assign we_a = draw_ok && !back_sel;
  assign we_b = draw_ok && back_sel;

  assign waddr_full = 7'(row[2:0]) * COLS7 + 7'(col[2:0]);
  assign raddr_full = 7'(scan_req.y) * COLS7 + 7'(scan_req.x);

  dbcs_frame_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk   (clk),
    .rst   (rst),
    .we    (we_a),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (glyph),
    .re    (scan_req.en),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (glyph_a)
  );

  dbcs_frame_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk   (clk),
    .rst   (rst),
    .we    (we_b),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (glyph),
    .re    (scan_req.en),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (glyph_b)
  );

  dbcs_scan_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (in_valid && in_ready && (cmd == CMD_PRESENT)),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .busy       (busy),
    .back_sel   (back_sel),
    .scan_req   (scan_req),
    .glyph_a    (glyph_a),
    .glyph_b    (glyph_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_valid (cell_valid),
    .out_col    (out_col),
    .out_row    (out_row),
    .out_glyph  (out_glyph),
    .last       (last)
  );

endmodule

// ----- hdl/dbcs_checker.sv -----
module dbcs_checker
  import dbcs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               cmd,
  input logic               out_valid,
  input logic               out_ready,
  input logic               cell_valid,
  input logic [POS_W-1:0]   out_col,
  input logic [POS_W-1:0]   out_row,
  input logic [GLYPH_W-1:0] out_glyph,
  input logic               last
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_valid) && $stable(out_col)
      && $stable(out_row) && $stable(out_glyph) && $stable(last))
    else $error("output beat changed while stalled");

  // A beat without a cell is the lone closing beat of a present.
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_valid |-> last && out_col == '0 && out_row == '0
      && out_glyph == '0)
    else $error("beat without a cell is not a clean closing beat");

  // A present occupies the block for at least the next cycle.
  a_present_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_PRESENT) |=> !in_ready)
    else $error("ready right after a present");

  // A draw never takes the block out of the ready state.
  a_draw_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_DRAW) |=> in_ready)
    else $error("draw dropped ready");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output busy after reset");

endmodule

bind double_buffered_cell_diff_screen_core dbcs_checker u_dbcs_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import dbcs_pkg::*;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [7:0]  col;
    logic signed [7:0]  row;
    logic [GLYPH_W-1:0] glyph;
  } screen_cmd_t;

  typedef struct packed {
    logic               cell_valid;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic [GLYPH_W-1:0] glyph;
    logic               last;
  } screen_beat_t;

  localparam int CELLS        = DEF_MAX_COLS * DEF_MAX_ROWS;
  localparam int SETTLE       = 12;
  localparam int IDLE_PCT     = 9;
  localparam int NUM_SETTINGS = 9;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_we    = 1'b0;
  logic               cfg_index = CFG_COLS;
  logic [REG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               cmd       = CMD_DRAW;
  logic signed [7:0]  col       = '0;
  logic signed [7:0]  row       = '0;
  logic [GLYPH_W-1:0] glyph     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               cell_valid;
  logic [POS_W-1:0]   out_col;
  logic [POS_W-1:0]   out_row;
  logic [GLYPH_W-1:0] out_glyph;
  logic               last;

  double_buffered_cell_diff_screen_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .col        (col),
    .row        (row),
    .glyph      (glyph),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_valid (cell_valid),
    .out_col    (out_col),
    .out_row    (out_row),
    .out_glyph  (out_glyph),
    .last       (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the screen state.
  logic [GLYPH_W-1:0] shadow_a [CELLS];
  logic [GLYPH_W-1:0] shadow_b [CELLS];
  logic               shadow_back_b;
  logic               shadow_first;
  logic [REG_W-1:0]   shadow_cols;
  logic [REG_W-1:0]   shadow_rows;

  screen_cmd_t  cmd_backlog[$];
  screen_beat_t expected_beats[$];
  screen_cmd_t  cur_cmd;
  screen_beat_t head_beat;

  logic calm = 1'b0;
  int   errors = 0;
  int   draws_taken = 0;
  int   presents_taken = 0;
  int   blank_presents = 0;
  int   beats_checked = 0;

  function automatic int unsigned eff_dim(input logic [REG_W-1:0] v, input int unsigned lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  task automatic apply_screen_cmd(input screen_cmd_t it);
    int unsigned  w;
    int unsigned  h;
    int unsigned  addr;
    int           n;
    logic [7:0]   c;
    logic [7:0]   r;
    logic [7:0]   bg;
    logic [7:0]   fg;
    screen_beat_t b;
    w = eff_dim(shadow_cols, DEF_MAX_COLS);
    h = eff_dim(shadow_rows, DEF_MAX_ROWS);
    if (it.cmd == CMD_DRAW) begin
      draws_taken++;
      c = it.col;
      r = it.row;
      // Negative coordinates have bit 7 set and fall out here as well.
      if (c < w && r < h) begin
        addr = r * DEF_MAX_COLS + c;
        if (shadow_back_b) begin
          shadow_b[addr] = it.glyph;
        end else begin
          shadow_a[addr] = it.glyph;
        end
      end
    end else begin
      presents_taken++;
      n = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          addr = y * DEF_MAX_COLS + x;
          bg = shadow_back_b ? shadow_b[addr] : shadow_a[addr];
          fg = shadow_back_b ? shadow_a[addr] : shadow_b[addr];
          if (shadow_first || bg != fg) begin
            b = '{cell_valid: 1'b1, col: POS_W'(x), row: POS_W'(y), glyph: bg, last: 1'b0};
            expected_beats.push_back(b);
            n++;
          end
        end
      end
      if (n == 0) begin
        blank_presents++;
        expected_beats.push_back('{cell_valid: 1'b0, col: '0, row: '0, glyph: '0, last: 1'b1});
      end else begin
        expected_beats[expected_beats.size()-1].last = 1'b1;
      end
      shadow_first  = 1'b0;
      shadow_back_b = ~shadow_back_b;
    end
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_screen_cmd(cur_cmd);
      end
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_cmd = cmd_backlog.pop_front();
          cmd      <= cur_cmd.cmd;
          col      <= cur_cmd.col;
          row      <= cur_cmd.row;
          glyph    <= cur_cmd.glyph;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every output beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got cell_valid %0d col %0d",
                 $time, cell_valid, out_col);
        $display("%0t: unexpected beat continued, row %0d glyph %0d last %0d",
                 $time, out_row, out_glyph, last);
      end else begin
        head_beat = expected_beats.pop_front();
        beats_checked++;
        check_field("cell_valid", head_beat.cell_valid, cell_valid);
        check_field("out_col", head_beat.col, out_col);
        check_field("out_row", head_beat.row, out_row);
        check_field("out_glyph", head_beat.glyph, out_glyph);
        check_field("last", head_beat.last, last);
      end
    end
    out_ready <= !rst && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_COLS) begin
      shadow_cols = val;
    end else begin
      shadow_rows = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_draw(input logic signed [7:0] c, input logic signed [7:0] r,
                           input logic [7:0] g);
    cmd_backlog.push_back('{cmd: CMD_DRAW, col: c, row: r, glyph: g});
  endtask

  task automatic push_present;
    cmd_backlog.push_back('{cmd: CMD_PRESENT, col: 8'($urandom), row: 8'($urandom),
                            glyph: 8'($urandom)});
  endtask

  // Waits until the sender is empty and every expected beat has come back.
  task automatic drain_all;
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || expected_beats.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic screen_cmd_t make_item(input int unsigned w, input int unsigned h);
    screen_cmd_t it;
    it.cmd   = CMD_DRAW;
    it.col   = 8'($urandom);
    it.row   = 8'($urandom);
    it.glyph = 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      it.cmd = CMD_PRESENT;
    end else if (w != 0 && h != 0 && $urandom_range(0, 4) != 0) begin
      it.col = 8'($urandom_range(0, w - 1));
      it.row = 8'($urandom_range(0, h - 1));
      // Spaces often match the other frame, which keeps some cells unchanged.
      if ($urandom_range(0, 3) == 0) begin
        it.glyph = GLYPH_SPACE;
      end
    end
    return it;
  endfunction

  int unsigned setting_cols [NUM_SETTINGS] = '{1, 3, 0, 15, 8, 1, 12, 5, 8};
  int unsigned setting_rows [NUM_SETTINGS] = '{1, 5, 4, 15, 1, 8, 3, 0, 8};

  initial begin
    int unsigned w;
    int unsigned h;
    int          count;
    for (int i = 0; i < CELLS; i++) begin
      shadow_a[i] = GLYPH_SPACE;
      shadow_b[i] = GLYPH_SPACE;
    end
    shadow_back_b = 1'b0;
    shadow_first  = 1'b1;
    shadow_cols   = COLS_RESET;
    shadow_rows   = ROWS_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset area of 8 by 8.
    @(negedge clk);
    push_present();
    push_draw(8'sd0, 8'sd0, 8'h00);
    push_draw(8'sd7, 8'sd7, 8'hFF);
    push_draw(-8'sd128, -8'sd128, 8'hAA);
    push_draw(8'sd127, 8'sd127, 8'h55);
    push_draw(-8'sd1, 8'sd3, 8'h11);
    push_draw(8'sd8, 8'sd0, 8'h22);
    push_draw(8'sd0, 8'sd8, 8'h33);
    push_draw(8'sd3, -8'sd1, 8'h44);
    push_present();
    push_present();
    // Restore the back frame so that both frames match and a present sends nothing.
    push_draw(8'sd0, 8'sd0, GLYPH_SPACE);
    push_draw(8'sd7, 8'sd7, GLYPH_SPACE);
    push_present();
    push_present();
    drain_all();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_reg(CFG_COLS, REG_W'(setting_cols[s]));
      write_reg(CFG_ROWS, REG_W'(setting_rows[s]));
      w = eff_dim(shadow_cols, DEF_MAX_COLS);
      h = eff_dim(shadow_rows, DEF_MAX_ROWS);
      calm = (s == 4);
      count = (w == 0 || h == 0) ? 16 : 62;
      @(negedge clk);
      for (int k = 0; k < count; k++) begin
        cmd_backlog.push_back(make_item(w, h));
        // Halfway through one setting the sender holds off until all beats are back.
        if (s == 1 && k == count / 2) begin
          drain_all();
        end
      end
      drain_all();
    end
    calm = 1'b0;

    $display("Run covered %0d draws and %0d presents over %0d area settings.",
             draws_taken, presents_taken, NUM_SETTINGS + 1);
    $display("%0d beats checked, %0d presents found no changed cell, %0d errors.",
             beats_checked, blank_presents, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d beats still expected.", expected_beats.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- double_buffered_cell_diff_screen_core.f -----
hdl/dbcs_pkg.sv
hdl/dbcs_frame_store.sv
hdl/dbcs_scan_ctrl.sv
hdl/double_buffered_cell_diff_screen_core.sv
hdl/dbcs_checker.sv
bench/testbench.sv
